FILE: sv/spq_pkg.sv
// Shared types and constants for the sorted priority queue.
`default_nettype none
package spq_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int TAG_WIDTH   = 16;
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic {
      REQ_ADD    = 1'b0,
      REQ_REMOVE = 1'b1
   } req_code_type;

   typedef enum logic [1:0] {
      STATUS_ADDED   = 2'd0,
      STATUS_REMOVED = 2'd1,
      STATUS_EMPTY   = 2'd2,
      STATUS_FULL    = 2'd3
   } status_type;

   typedef enum logic {
      ST_IDLE   = 1'b0,
      ST_RESULT = 1'b1
   } state_type;

   // Controller to datapath commands.
   typedef struct packed {
      logic             load;    // capture a result word this cycle
      logic             insert;  // shift-insert the incoming entry
      logic             pop;     // shift all cells toward the front
      status_type       status;
      logic [CNT_W-1:0] count;   // occupied cells before this operation
   } cmd_type;

endpackage
`default_nettype wire

FILE: sv/spq_datapath.sv
// Datapath: shift-register cells with per-cell compare and result register.
`default_nettype none
module spq_datapath import spq_pkg::*; (
   input  wire logic               clock,
   input  wire cmd_type            cmd,
   input  wire logic        [15:0] item_tag,
   input  wire logic signed [15:0] item_priority,
   output logic             [1:0]  out_status,
   output logic             [15:0] out_tag,
   output logic signed      [15:0] out_priority
);

   logic        [TAG_WIDTH-1:0] tag_ff  [QUEUE_DEPTH];
   logic signed [15:0]          prio_ff [QUEUE_DEPTH];
   logic        [TAG_WIDTH-1:0] tag_in  [QUEUE_DEPTH];
   logic signed [15:0]          prio_in [QUEUE_DEPTH];

   logic        [TAG_WIDTH-1:0] tag_prev  [QUEUE_DEPTH];
   logic signed [15:0]          prio_prev [QUEUE_DEPTH];
   logic        [TAG_WIDTH-1:0] tag_next  [QUEUE_DEPTH];
   logic signed [15:0]          prio_next [QUEUE_DEPTH];
   logic [QUEUE_DEPTH-1:0]      ahead;
   logic [QUEUE_DEPTH-1:0]      ahead_prev;

   logic [TAG_WIDTH+15:0]       tag_wide_in;
   logic [TAG_WIDTH+15:0]       tag_wide_out;
   logic [TAG_WIDTH-1:0]        new_tag;

   logic        [1:0]           status_ff, status_in;
   logic        [15:0]          otag_ff, otag_in;
   logic signed [15:0]          oprio_ff, oprio_in;

   assign tag_wide_in  = {{TAG_WIDTH{1'b0}}, item_tag};
   assign new_tag      = tag_wide_in[TAG_WIDTH-1:0];
   assign tag_wide_out = {16'b0, tag_ff[0]};

   always_comb begin
      tag_prev[0]   = new_tag;
      prio_prev[0]  = item_priority;
      ahead_prev[0] = 1'b0;
      tag_next[QUEUE_DEPTH-1]  = tag_ff[QUEUE_DEPTH-1];
      prio_next[QUEUE_DEPTH-1] = prio_ff[QUEUE_DEPTH-1];
      // An occupied cell stays in place when it outranks the new entry.
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         ahead[i] = (CNT_W'(i) < cmd.count) && (prio_ff[i] > item_priority);
      end
      for (int i = 1; i < QUEUE_DEPTH; i++) begin
         tag_prev[i]   = tag_ff[i-1];
         prio_prev[i]  = prio_ff[i-1];
         ahead_prev[i] = ahead[i-1];
         tag_next[i-1]  = tag_ff[i];
         prio_next[i-1] = prio_ff[i];
      end
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         tag_in[i]  = tag_ff[i];
         prio_in[i] = prio_ff[i];
         if (cmd.insert && !ahead[i]) begin
            if (ahead_prev[i]) begin
               tag_in[i]  = new_tag;
               prio_in[i] = item_priority;
            end else begin
               tag_in[i]  = tag_prev[i];
               prio_in[i] = prio_prev[i];
            end
         end else if (cmd.pop) begin
            tag_in[i]  = tag_next[i];
            prio_in[i] = prio_next[i];
         end
      end
   end

   always_comb begin
      status_in = status_ff;
      otag_in   = otag_ff;
      oprio_in  = oprio_ff;
      if (cmd.load) begin
         status_in = cmd.status;
         if (cmd.pop) begin
            otag_in  = tag_wide_out[15:0];
            oprio_in = prio_ff[0];
         end else begin
            otag_in  = 16'd0;
            oprio_in = 16'sd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         tag_ff[i]  <= tag_in[i];
         prio_ff[i] <= prio_in[i];
      end
      status_ff <= status_in;
      otag_ff   <= otag_in;
      oprio_ff  <= oprio_in;
   end

   assign out_status   = status_ff;
   assign out_tag      = otag_ff;
   assign out_priority = oprio_ff;

endmodule
`default_nettype wire

FILE: sv/spq_controller.sv
// Controller: handshake state machine, entry count and command decode.
`default_nettype none
module spq_controller import spq_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_valid,
   output logic      req_ready,
   input  wire logic req_type,
   output logic      rsp_valid,
   input  wire logic rsp_ready,
   output cmd_type   cmd
);

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             accept;
   logic             full, empty;

   assign full   = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign empty  = (count_ff == '0);
   assign accept = req_valid && req_ready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = ST_RESULT;
         end
         ST_RESULT: begin
            if (accept) state_in = ST_RESULT;
            else if (rsp_ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
         end
         ST_RESULT: begin
            rsp_valid = 1'b1;
            req_ready = rsp_ready;  // new word replaces the one being taken
         end
         default: begin
            req_ready = 1'b0;
            rsp_valid = 1'b0;
         end
      endcase
   end

   always_comb begin
      cmd.load   = accept;
      cmd.insert = 1'b0;
      cmd.pop    = 1'b0;
      cmd.status = STATUS_ADDED;
      cmd.count  = count_ff;
      count_in   = count_ff;
      if (req_type == REQ_ADD) begin
         if (full) begin
            cmd.status = STATUS_FULL;
         end else begin
            cmd.status = STATUS_ADDED;
            cmd.insert = accept;
            if (accept) count_in = count_ff + CNT_W'(1);
         end
      end else begin
         if (empty) begin
            cmd.status = STATUS_EMPTY;
         end else begin
            cmd.status = STATUS_REMOVED;
            cmd.pop    = accept;
            if (accept) count_in = count_ff - CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

endmodule
`default_nettype wire

FILE: sv/sorted_priority_queue.sv
// Top level of the sorted priority queue.
// Usage:
//  - Request channel (req_valid/req_ready): req_type selects add or remove;
//    req_item_tag and req_item_priority are used on add only.
//  - Response channel (rsp_valid/rsp_ready): one word per request with
//    rsp_status (added, removed, empty, full) and, on a remove, the tag
//    and priority of the front entry; zero otherwise.
//  - Entries sit in a row of shift-register cells kept in serving order;
//    each cell compares its priority with the incoming one, so an add or
//    a remove completes in the cycle it is accepted.
//  - Latency: the response word is valid the cycle after acceptance.
//  - Throughput: one request per cycle while the response is taken each
//    cycle; the single response register sets that figure.
//  - A stalled receiver holds the response word; a new request is taken
//    only in a cycle where the held word is taken.
//  - Reset empties the queue and drops any pending response.
`default_nettype none
module sorted_priority_queue import spq_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic               req_type,
   input  wire logic        [15:0] req_item_tag,
   input  wire logic signed [15:0] req_item_priority,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic             [1:0]  rsp_status,
   output logic             [15:0] rsp_out_tag,
   output logic signed      [15:0] rsp_out_priority
);

   cmd_type cmd;

   spq_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_type  (req_type),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   spq_datapath u_datapath (
      .clock         (clock),
      .cmd           (cmd),
      .item_tag      (req_item_tag),
      .item_priority (req_item_priority),
      .out_status    (rsp_status),
      .out_tag       (rsp_out_tag),
      .out_priority  (rsp_out_priority)
   );

endmodule
`default_nettype wire
